@@ rtl/utt_pkg.sv @@
package utt_pkg;

   // code point width after pair assembly (up to 0x10FFFF)
   localparam int CP_W = 21;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // encoded length codes: number of bytes minus one
   localparam logic [1:0] LEN_ONE   = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd1;
   localparam logic [1:0] LEN_THREE = 2'd2;
   localparam logic [1:0] LEN_FOUR  = 2'd3;

   // unit classification limits
   localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;
   localparam logic [4:0]  SURR_PREFIX    = 5'b11011;
   localparam logic [CP_W-1:0] SUPP_BASE  = 21'h10000;

   // source mode values
   localparam logic MODE_LATIN1 = 1'b0;
   localparam logic MODE_UTF16  = 1'b1;

   // one classified request waiting for the byte emitter
   typedef struct packed {
      logic [CP_W-1:0] cp;
      logic [1:0]      len;
      logic            err;
   } entry_type;

   // byte number idx of the utf-8 form of an entry
   function automatic logic [7:0] encode_byte(input entry_type e, input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (e.len)
         LEN_ONE: begin
            b = e.cp[7:0];
         end
         LEN_TWO: begin
            case (idx)
               2'd0:    b = {3'b110, e.cp[10:6]};
               default: b = {2'b10, e.cp[5:0]};
            endcase
         end
         LEN_THREE: begin
            case (idx)
               2'd0:    b = {4'b1110, e.cp[15:12]};
               2'd1:    b = {2'b10, e.cp[11:6]};
               default: b = {2'b10, e.cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, e.cp[20:18]};
               2'd1:    b = {2'b10, e.cp[17:12]};
               2'd2:    b = {2'b10, e.cp[11:6]};
               default: b = {2'b10, e.cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

endpackage

@@ rtl/utt_front.sv @@
module utt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic               csr_source_mode,
   input  logic               accept,
   input  logic [15:0]        unit,
   input  logic               final_req,
   output logic               q_push,
   output utt_pkg::entry_type q_entry
);
   import utt_pkg::*;

   logic       source_mode_ff, source_mode_in;
   logic       pair_pending_ff, pair_pending_in;
   logic [9:0] high_bits_ff, high_bits_in;
   logic       is_surr;
   logic       push_c;
   entry_type  entry_c;

   assign is_surr = (unit[15:11] == SURR_PREFIX);

   // classify the request and update the pair state
   always_comb begin
      source_mode_in  = csr_write_enable ? csr_source_mode : source_mode_ff;
      pair_pending_in = pair_pending_ff;
      high_bits_in    = high_bits_ff;
      push_c          = 1'b0;
      entry_c.cp      = {{(CP_W-16){1'b0}}, unit};
      entry_c.err     = 1'b0;
      if (unit < ONE_BYTE_LIMIT) begin
         entry_c.len = LEN_ONE;
      end else if (unit < TWO_BYTE_LIMIT) begin
         entry_c.len = LEN_TWO;
      end else begin
         entry_c.len = LEN_THREE;
      end
      if (accept) begin
         if (source_mode_ff == MODE_LATIN1) begin
            // latin-1 byte, any held half is dropped
            pair_pending_in = 1'b0;
            high_bits_in    = 10'd0;
            push_c          = 1'b1;
            entry_c.cp      = {{(CP_W-8){1'b0}}, unit[7:0]};
            entry_c.len     = unit[7] ? LEN_TWO : LEN_ONE;
         end else if (pair_pending_ff) begin
            // second half completes a supplementary code point
            pair_pending_in = 1'b0;
            high_bits_in    = 10'd0;
            push_c          = 1'b1;
            entry_c.cp      = SUPP_BASE + {1'b0, high_bits_ff, unit[9:0]};
            entry_c.len     = LEN_FOUR;
         end else if (is_surr) begin
            if (final_req) begin
               // text ends on an unpaired half
               push_c      = 1'b1;
               entry_c.cp  = '0;
               entry_c.len = LEN_ONE;
               entry_c.err = 1'b1;
            end else begin
               pair_pending_in = 1'b1;
               high_bits_in    = unit[9:0];
            end
         end else begin
            push_c = 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         source_mode_ff  <= MODE_UTF16;
         pair_pending_ff <= 1'b0;
         high_bits_ff    <= 10'd0;
      end else begin
         source_mode_ff  <= source_mode_in;
         pair_pending_ff <= pair_pending_in;
         high_bits_ff    <= high_bits_in;
      end
   end

   assign q_push  = push_c;
   assign q_entry = entry_c;

endmodule

@@ rtl/utt_queue.sv @@
module utt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  utt_pkg::entry_type push_entry,
   input  logic               pop,
   output utt_pkg::entry_type head,
   output logic               empty,
   output logic               full
);
   import utt_pkg::*;

   entry_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entries_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/utt_back.sv @@
module utt_back (
   input  logic               clock,
   input  logic               reset,
   input  utt_pkg::entry_type head,
   input  logic               q_empty,
   output logic               q_pop,
   output logic [7:0]         out_byte,
   output logic               last_of_run,
   output logic               error,
   output logic               out_empty,
   input  logic               out_pop
);
   import utt_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       err_ff, err_in;
   logic       load;
   logic       at_end;

   // output slot frees when empty or taken this cycle
   assign load   = (!valid_ff || out_pop) && !q_empty;
   assign at_end = (idx_ff == head.len);

   // emit one byte of the head entry per cycle while the output slot is free
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = encode_byte(head, idx_ff);
         last_in  = at_end;
         err_in   = head.err;
         idx_in   = at_end ? 2'd0 : idx_ff + 1'b1;
      end else if (out_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign q_pop       = load && at_end;
   assign out_byte    = byte_ff;
   assign last_of_run = last_ff;
   assign error       = err_ff;
   assign out_empty   = !valid_ff;

endmodule

@@ rtl/utf16_to_utf8_transcoder_unit.sv @@
// UTF-16 to UTF-8 transcoder.
// Request side is a queue write port: a request (req_unit, req_final_req) is
// taken at a clock edge with req_push high and req_full low.
// Result side is a queue read port: while rsp_empty is low the oldest byte
// (rsp_out_byte, rsp_last_of_run, rsp_error) is shown; rsp_pop takes it.
// csr_write_enable loads csr_source_mode (1 = UTF-16, 0 = Latin-1 bytes);
// write it only while the block is idle.
// The first byte of a request passes through the queue and then the output
// register before it is shown. The byte emitter sends one byte per cycle
// while the receiver takes them, so a request yields one to four bytes (one
// to three for a basic-plane unit, four for a completed pair, none for a held
// first half). The front takes a request every cycle while the four-entry
// queue between front and emitter has room; req_full follows that queue.
// Reset (synchronous, active high) empties the queue and output register,
// clears any held surrogate half and sets UTF-16 mode.
// When the receiver holds rsp_pop low, the output byte stays put, the queue
// fills and req_full then rises.
module utf16_to_utf8_transcoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_unit,
   input  logic        req_final_req,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_of_run,
   output logic        rsp_error,
   input  logic        csr_write_enable,
   input  logic        csr_source_mode
);
   import utt_pkg::*;

   logic      accept;
   logic      q_push;
   entry_type q_entry;
   entry_type q_head;
   logic      q_empty;
   logic      q_full;
   logic      q_pop;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   // classifier and pair state
   utt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_source_mode  (csr_source_mode),
      .accept           (accept),
      .unit             (req_unit),
      .final_req        (req_final_req),
      .q_push           (q_push),
      .q_entry          (q_entry)
   );

   // decoupling queue
   utt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty),
      .full       (q_full)
   );

   // byte emitter
   utt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .out_byte    (rsp_out_byte),
      .last_of_run (rsp_last_of_run),
      .error       (rsp_error),
      .out_empty   (rsp_empty),
      .out_pop     (rsp_pop)
   );

endmodule

@@ rtl/utt_checker.sv @@
module utt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last_of_run,
   input logic       rsp_error
);

   // nothing is shown right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result shown after reset");

   // an error result stands alone with a zero byte
   a_error_alone: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> (rsp_last_of_run && rsp_out_byte == 8'h00))
      else $error("error result malformed");

   // a multi-byte lead byte never ends a run
   a_lead_not_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_error && rsp_out_byte[7:6] == 2'b11) |-> !rsp_last_of_run)
      else $error("lead byte marked last");

   // a continuation byte that is not last is followed by another continuation
   a_cont_chain: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && rsp_out_byte[7:6] == 2'b10 && !rsp_last_of_run)
      ##1 !rsp_empty |-> (rsp_out_byte[7:6] == 2'b10 && !rsp_error))
      else $error("broken continuation sequence");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte)))
      else $error("stalled result changed");

endmodule

bind utf16_to_utf8_transcoder_unit utt_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_error       (rsp_error)
);
